// ===== rtl/bsa_pkg.sv =====
// Shared types and constants for the binned statistics accumulator.
`default_nettype none
package bsa_pkg;
  localparam logic [1:0] MODE_SUM  = 2'd0;
  localparam logic [1:0] MODE_AVG  = 2'd1;
  localparam logic [1:0] MODE_WAVG = 2'd2;
  localparam logic [1:0] MODE_LAST = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_ZERODEN = 2'd2;

  // Register byte addresses
  localparam logic [1:0] REG_STAT_MODE = 2'd0;

  localparam int SUM_W = 64;
  localparam int DEN_W = 40;
  localparam logic [DEN_W-1:0] DEN_MAX = '1;

  // Result handed from the datapath to the output stage
  typedef struct packed {
    logic [31:0] stat;
    logic        seen;
    logic [1:0]  status;
  } bsa_res_t;
endpackage
`default_nettype wire

// ===== rtl/bsa_div.sv =====
// Sequential restoring divider: 64-bit magnitude by 40-bit divisor, one bit per cycle.
`default_nettype none
module bsa_div
  import bsa_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [SUM_W-1:0]      quot_o
);
  logic [SUM_W-1:0] q_q, q_d;
  logic [DEN_W-1:0] r_q, r_d;
  logic [DEN_W-1:0] dv_q;
  logic [6:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, done_d;
  logic [DEN_W:0]   trial;

  // One quotient bit per step
  always_comb begin
    q_d = q_q; r_d = r_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      q_d = num_i; r_d = '0; cnt_d = 7'(SUM_W); busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {r_q, q_q[SUM_W-1]};
      q_d = {q_q[SUM_W-2:0], 1'b0};
      if (trial >= {1'b0, dv_q}) begin
        r_d = DEN_W'(trial - {1'b0, dv_q});
        q_d[0] = 1'b1;
      end else begin
        r_d = trial[DEN_W-1:0];
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; done_o <= 1'b0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; done_o <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d;
    if (start_i) dv_q <= den_i;
  end

  assign quot_o = q_q;
endmodule
`default_nettype wire

// ===== rtl/binned_statistics_accumulator.sv =====
// Top level of the binned statistics accumulator.
// Bins (period, region) live in one synchronous memory of PERIODS*REGIONS words of
// 104 bits (sum, denominator), plus a REGIONS-deep seen-flag memory. After reset a
// clearing pass writes zero to every bin, one bin per cycle, while s_axis_tready
// stays low. One request is in flight at a time. An update, a sum or last-value
// read, or an average or weighted read of a bin with a zero denominator passes
// through the read, modify and write, and output steps before the next request can
// be taken. An average or weighted read of a nonzero denominator also runs a
// one-bit-per-cycle divider in the divide state before the output step.
// Out-of-range requests go straight to the output step. The result waits in an
// output register and the next request may be accepted while it does; a request
// whose result is ready stalls in the output state while that register is full and
// not being drained.
`default_nettype none
module binned_statistics_accumulator
  import bsa_pkg::*;
#(
  parameter int PERIODS = 16,
  parameter int REGIONS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: period[3:0], region_id[14:4], value[46:15], weight[62:47], zero[63]
  input  wire logic [63:0] s_axis_tdata,
  // tuser: req_type
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: stat_value[31:0], region_seen[32], status[34:33], zero[39:35]
  output logic [39:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int BINS = PERIODS * REGIONS;
  localparam int RW   = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int BW   = (BINS > 1) ? $clog2(BINS) : 1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EXE  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] st_q, st_d;
  logic [1:0] mode_q;
  logic [BW:0] clr_q;

  // APB register
  assign pready = 1'b1;
  assign prdata = {30'd0, mode_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= MODE_SUM;
    else if (psel && penable && pwrite && paddr == REG_STAT_MODE) mode_q <= pwdata[1:0];
  end

  // Input fields
  logic [3:0]  in_per;
  logic [10:0] in_reg;
  logic        in_ok;
  assign in_per = s_axis_tdata[3:0];
  assign in_reg = s_axis_tdata[14:4];
  assign in_ok  = !in_reg[10] && ({21'd0, in_reg} < 32'(REGIONS))
                  && ({28'd0, in_per} < 32'(PERIODS));

  // Captured request
  logic                 rd_q;
  logic [BW-1:0]        idx_q;
  logic [RW-1:0]        rid_q;
  logic signed [31:0]   val_q;
  logic [15:0]          wt_q;

  // Memories
  logic [SUM_W+DEN_W-1:0] bin_mem [BINS];
  logic                   seen_mem [REGIONS];
  logic [SUM_W+DEN_W-1:0] bin_rd;
  logic                   seen_rd;
  logic                   bin_we;
  logic [BW-1:0]          bin_wa;
  logic [SUM_W+DEN_W-1:0] bin_wd;

  always_ff @(posedge clk_i) begin
    if (bin_we) bin_mem[bin_wa] <= bin_wd;
    bin_rd <= bin_mem[idx_q];
  end
  // Seen flags are cleared during the clearing pass, while the clear counter is below REGIONS
  always_ff @(posedge clk_i) begin
    if (st_q == S_CLR) begin
      if (clr_q < (BW+1)'(REGIONS)) seen_mem[RW'(clr_q)] <= 1'b0;
    end else if (st_q == S_EXE && !rd_q) seen_mem[rid_q] <= 1'b1;
    seen_rd <= seen_mem[rid_q];
  end

  // Modify path
  logic signed [SUM_W-1:0] sum_old, addend, sum_add, sum_new;
  logic [DEN_W-1:0] den_old, den_new;
  logic [DEN_W:0]   den_sum;
  logic signed [47:0] prod_q;
  assign sum_old = bin_rd[SUM_W+DEN_W-1:DEN_W];
  assign den_old = bin_rd[DEN_W-1:0];

  always_ff @(posedge clk_i) prod_q <= val_q * $signed({1'b0, wt_q});

  always_comb begin
    addend = (mode_q == MODE_WAVG) ? SUM_W'(prod_q) : SUM_W'(val_q);
    sum_add = sum_old + addend;
    if (!sum_old[SUM_W-1] && !addend[SUM_W-1] && sum_add[SUM_W-1])
      sum_add = {1'b0, {(SUM_W-1){1'b1}}};
    else if (sum_old[SUM_W-1] && addend[SUM_W-1] && !sum_add[SUM_W-1])
      sum_add = {1'b1, {(SUM_W-1){1'b0}}};
    den_sum = '0;
    unique case (mode_q)
      MODE_SUM: begin sum_new = sum_add; den_new = '0; end
      MODE_AVG: begin
        sum_new = sum_add;
        den_sum = {1'b0, den_old} + (DEN_W+1)'(1);
        den_new = den_sum[DEN_W] ? DEN_MAX : den_sum[DEN_W-1:0];
      end
      MODE_WAVG: begin
        sum_new = sum_add;
        den_sum = {1'b0, den_old} + (DEN_W+1)'(wt_q);
        den_new = den_sum[DEN_W] ? DEN_MAX : den_sum[DEN_W-1:0];
      end
      default: begin sum_new = SUM_W'(val_q); den_new = '0; end
    endcase
  end

  always_comb begin
    bin_we = 1'b0; bin_wa = idx_q; bin_wd = {sum_new, den_new};
    if (st_q == S_CLR) begin
      bin_we = 1'b1; bin_wa = clr_q[BW-1:0]; bin_wd = '0;
    end else if (st_q == S_EXE && !rd_q) bin_we = 1'b1;
  end

  // Divider and saturation
  logic neg_q, div_done;
  logic [SUM_W-1:0] mag, quot;
  assign mag = sum_old[SUM_W-1] ? (~sum_old + SUM_W'(1)) : sum_old;
  bsa_div u_div (
    .clk_i, .rst_ni,
    .start_i (st_q == S_EXE && rd_q && (mode_q == MODE_AVG || mode_q == MODE_WAVG)
              && den_old != '0),
    .num_i   (mag),
    .den_i   (den_old),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  logic [31:0] sat_sum, sat_q;
  always_comb begin
    if (sum_old > 64'sh7FFFFFFF) sat_sum = 32'h7FFFFFFF;
    else if (sum_old < -64'sh80000000) sat_sum = 32'h80000000;
    else sat_sum = sum_old[31:0];
    if (neg_q) sat_q = (quot > 64'h80000000) ? 32'h80000000 : (~quot[31:0] + 32'd1);
    else sat_q = (quot > 64'h7FFFFFFF) ? 32'h7FFFFFFF : quot[31:0];
  end

  // Sequencer and output register
  bsa_res_t res_q;
  logic     out_v_q, seen_hold_q;
  logic     accept, out_free;
  assign out_free = !out_v_q || m_axis_tready;
  assign s_axis_tready = (st_q == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_CLR:  if (clr_q == (BW+1)'(BINS - 1)) st_d = S_IDLE;
      S_IDLE: if (accept) st_d = in_ok ? S_RD : S_OUT;
      S_RD:   st_d = S_EXE;
      S_EXE:  st_d = (rd_q && (mode_q == MODE_AVG || mode_q == MODE_WAVG)
                      && den_old != '0) ? S_DIV : S_OUT;
      S_DIV:  if (div_done) st_d = S_OUT;
      S_OUT:  if (out_free) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_q <= '0; out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == S_CLR) clr_q <= clr_q + (BW+1)'(1);
      if (st_q == S_OUT && out_free) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q  <= s_axis_tuser;
      idx_q <= BW'({28'd0, in_per} * 32'(REGIONS) + {21'd0, in_reg});
      rid_q <= RW'(in_reg);
      val_q <= s_axis_tdata[46:15];
      wt_q  <= s_axis_tdata[62:47];
      res_q <= '{stat: 32'd0, seen: 1'b0, status: in_ok ? ST_OK : ST_IGNORED};
    end
    if (st_q == S_EXE) begin
      neg_q <= sum_old[SUM_W-1];
      seen_hold_q <= seen_rd;
      if (!rd_q) res_q <= '{stat: 32'd0, seen: 1'b1, status: ST_OK};
      else if (mode_q == MODE_AVG || mode_q == MODE_WAVG) begin
        if (den_old == '0) res_q <= '{stat: 32'd0, seen: seen_rd, status: ST_ZERODEN};
      end else res_q <= '{stat: sat_sum, seen: seen_rd, status: ST_OK};
    end
    if (st_q == S_DIV && div_done)
      res_q <= '{stat: sat_q, seen: seen_hold_q, status: ST_OK};
    if (st_q == S_OUT && out_free)
      m_axis_tdata <= {5'd0, res_q.status, res_q.seen, res_q.stat};
  end

  assign m_axis_tvalid = out_v_q;
endmodule
`default_nettype wire

// ===== rtl/bsa_checker.sv =====
// Port-level checks for the binned statistics accumulator.
`default_nettype none
module bsa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[34:33] != 2'd3)
    else $error("bad status code");
  a_ign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[34:33] != 2'd0 |-> m_axis_tdata[31:0] == 32'd0)
    else $error("nonzero statistic on error");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while busy");
endmodule

bind binned_statistics_accumulator bsa_checker u_bsa_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire
